/* design/ama_pkg.sv */
// shared types and constants for the accelerometer moving average block
// no dependencies; used by all modules in this folder
`default_nettype none

package ama_pkg;

	localparam int LOG2_DEPTH_DEF = 3;

	// scaled sample, running sum, output, offset, raw and product widths; axis count
	localparam int SMP_W  = 16;
	localparam int SUM_W  = 17;
	localparam int OUT_W  = 17;
	localparam int OFF_W  = 16;
	localparam int RAW_W  = 8;
	localparam int PROD_W = 22;
	localparam int AXES   = 3;
	localparam int WORD_W = AXES * SMP_W;

	localparam int SCALE_MUL   = 10000;
	localparam int SCALE_SHIFT = 6;

	// input commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// ring memory control
	typedef struct packed {
		logic clr;
		logic rd_en;
		logic wr_en;
	} ring_ctl_t;

endpackage

`default_nettype wire

/* design/ama_scale.sv */
// scaling of one raw accelerometer byte: sign extend, times 10000, asr 6
// depends on ama_pkg
`default_nettype none

module ama_scale (
	input  wire logic [ama_pkg::RAW_W-1:0]        raw,
	output logic signed [ama_pkg::SMP_W-1:0]      scaled
);

	logic signed [ama_pkg::PROD_W-1:0] raw_ext;
	logic signed [ama_pkg::PROD_W-1:0] prod;

	always_comb begin
		raw_ext = $signed({{(ama_pkg::PROD_W-ama_pkg::RAW_W){raw[ama_pkg::RAW_W-1]}}, raw});
		prod    = raw_ext * $signed(ama_pkg::PROD_W'(ama_pkg::SCALE_MUL));
		// floor shift; the result always fits the sample width
		scaled  = prod[ama_pkg::SCALE_SHIFT +: ama_pkg::SMP_W];
	end

endmodule

`default_nettype wire

/* design/ama_ring.sv */
// sample ring memory with registered read and per-entry valid bits
// depends on ama_pkg; an entry that is not valid reads as zero
`default_nettype none

module ama_ring #(
	parameter int LOG2_DEPTH = ama_pkg::LOG2_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ama_pkg::ring_ctl_t           ctl,
	input  wire logic [LOG2_DEPTH-1:0]        rd_addr,
	input  wire logic [LOG2_DEPTH-1:0]        wr_addr,
	input  wire logic [ama_pkg::WORD_W-1:0]   wr_data,
	output logic [ama_pkg::WORD_W-1:0]        rd_data
);

	localparam int DEPTH = 1 << LOG2_DEPTH;

	logic [ama_pkg::WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;
	logic [ama_pkg::WORD_W-1:0] rd_data_q;
	logic                       rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* design/accel_moving_average_offset.sv */
// accelerometer moving average with offsets: a sample word takes a ring read,
// then a sum update and write back; a result word is valid the cycle after
// the update. a clear word needs no update step. no new word is taken until
// the update is written back. reset clears the ring valid bits, sums, slot,
// warm-up counter and offsets at once; no clearing pass.
// depends on ama_pkg, ama_scale, ama_ring
`default_nettype none

module accel_moving_average_offset #(
	parameter int LOG2_DEPTH = ama_pkg::LOG2_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               cmd,
	input  wire logic [ama_pkg::RAW_W-1:0]          raw_first,
	input  wire logic [ama_pkg::RAW_W-1:0]          raw_second,
	input  wire logic [ama_pkg::RAW_W-1:0]          raw_third,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [ama_pkg::OUT_W-1:0]        axis_x,
	output logic signed [ama_pkg::OUT_W-1:0]        axis_y,
	output logic signed [ama_pkg::OUT_W-1:0]        axis_z,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ama_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ama_pkg::OFF_W-1:0]          cfg_data
);

	localparam int SMP_W = ama_pkg::SMP_W;
	localparam int SUM_W = ama_pkg::SUM_W;
	localparam int DIF_W = SUM_W + 1;
	localparam logic [LOG2_DEPTH-1:0] SLOT_MAX = '1;

	ama_pkg::state_t state_q, state_nxt;

	logic signed [SMP_W-1:0]         scl [ama_pkg::AXES];
	logic signed [SMP_W-1:0]         scl_s1 [ama_pkg::AXES];
	logic signed [SMP_W-1:0]         old_smp [ama_pkg::AXES];
	logic signed [SUM_W-1:0]         sum_q [ama_pkg::AXES];
	logic signed [SUM_W-1:0]         sum_nxt [ama_pkg::AXES];
	logic signed [SMP_W-1:0]         new_sh;
	logic signed [SMP_W-1:0]         old_sh;
	logic signed [ama_pkg::OFF_W-1:0] off_x_q, off_y_q, off_z_q;
	logic signed [DIF_W-1:0]         res_x, res_y, res_z;
	logic [LOG2_DEPTH-1:0]           slot_q;
	logic [LOG2_DEPTH-1:0]           warm_q, warm_nxt;
	logic                            out_valid_q;
	logic signed [ama_pkg::OUT_W-1:0] axis_x_q, axis_y_q, axis_z_q;
	logic                            accept, do_clear, do_sample, emit, commit;
	ama_pkg::ring_ctl_t              ring_ctl;
	logic [ama_pkg::WORD_W-1:0]      rd_data;
	logic [ama_pkg::WORD_W-1:0]      wr_data;

	// the second byte feeds the first axis and the first byte the second
	ama_scale u_scale_x (.raw(raw_second), .scaled(scl[0]));
	ama_scale u_scale_y (.raw(raw_first),  .scaled(scl[1]));
	ama_scale u_scale_z (.raw(raw_third),  .scaled(scl[2]));

	ama_ring #(.LOG2_DEPTH(LOG2_DEPTH)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.rd_addr (slot_q),
		.wr_addr (slot_q),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	assign in_stall  = (state_q != ama_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign axis_x    = axis_x_q;
	assign axis_y    = axis_y_q;
	assign axis_z    = axis_z_q;

	always_comb begin
		accept    = in_valid & ~in_stall;
		do_clear  = accept & (cmd == ama_pkg::CMD_CLEAR);
		do_sample = accept & (cmd == ama_pkg::CMD_SAMPLE);
		warm_nxt  = (warm_q == SLOT_MAX) ? warm_q : warm_q + 1'b1;
		emit      = (warm_nxt == SLOT_MAX);
		// hold the update while an earlier result still waits
		commit    = (state_q == ama_pkg::ST_UPDATE) & ~(emit & out_valid_q & out_stall);

		for (int a = 0; a < ama_pkg::AXES; a++) begin
			old_smp[a] = rd_data[a*SMP_W +: SMP_W];
			new_sh     = scl_s1[a] >>> LOG2_DEPTH;
			old_sh     = old_smp[a] >>> LOG2_DEPTH;
			sum_nxt[a] = sum_q[a] + SUM_W'(new_sh) - SUM_W'(old_sh);
		end
		wr_data = {scl_s1[2], scl_s1[1], scl_s1[0]};

		res_x = -DIF_W'(sum_nxt[0]) - DIF_W'(off_x_q);
		res_y =  DIF_W'(sum_nxt[1]) - DIF_W'(off_y_q);
		res_z =  DIF_W'(sum_nxt[2]) - DIF_W'(off_z_q);

		ring_ctl.clr   = do_clear;
		ring_ctl.rd_en = do_sample;
		ring_ctl.wr_en = commit;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ama_pkg::ST_IDLE: begin
				if (do_sample) begin
					state_nxt = ama_pkg::ST_UPDATE;
				end
			end
			ama_pkg::ST_UPDATE: begin
				if (commit) begin
					state_nxt = ama_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ama_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ama_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_sample) begin
			for (int a = 0; a < ama_pkg::AXES; a++) begin
				scl_s1[a] <= scl[a];
			end
		end
		if (commit && emit) begin
			axis_x_q <= res_x[ama_pkg::OUT_W-1:0];
			axis_y_q <= res_y[ama_pkg::OUT_W-1:0];
			axis_z_q <= res_z[ama_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < ama_pkg::AXES; a++) begin
				sum_q[a] <= '0;
			end
			slot_q      <= '0;
			warm_q      <= '0;
			out_valid_q <= 1'b0;
			off_x_q     <= '0;
			off_y_q     <= '0;
			off_z_q     <= '0;
		end else begin
			if (do_clear) begin
				for (int a = 0; a < ama_pkg::AXES; a++) begin
					sum_q[a] <= '0;
				end
				slot_q <= '0;
				warm_q <= '0;
			end else if (commit) begin
				for (int a = 0; a < ama_pkg::AXES; a++) begin
					sum_q[a] <= sum_nxt[a];
				end
				slot_q <= slot_q + 1'b1;
				warm_q <= warm_nxt;
			end

			if (commit && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					ama_pkg::REG_OFFSET_X: off_x_q <= cfg_data;
					ama_pkg::REG_OFFSET_Y: off_y_q <= cfg_data;
					ama_pkg::REG_OFFSET_Z: off_z_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire
